>>> rtl/core/skvt_pkg.sv
// Package for the sorted key/datum table: operation and status codes, defaults.
// No dependencies.
`timescale 1ns / 1ps
package skvt_pkg;

    localparam int ENTRIES_DEFAULT    = 16;
    localparam int DATUM_BITS_DEFAULT = 32;
    localparam int KEY_BITS           = 32;
    localparam int PORT_DATUM_BITS    = 32;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_FIND   = 3'd2,
        OP_FIRST  = 3'd3,
        OP_NEXT   = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_CURSOR    = 2'd3
    } status_t;

endpackage

>>> rtl/core/skvt_req_if.sv
// Request channel interface of the sorted key/datum table.
// Depends on skvt_pkg.
`timescale 1ns / 1ps
interface skvt_req_if
    import skvt_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic signed [KEY_BITS-1:0] key_in;
    logic [PORT_DATUM_BITS-1:0] datum_in;

    modport source (output valid, mode, key_in, datum_in, input ready);
    modport sink   (input valid, mode, key_in, datum_in, output ready);
endinterface

>>> rtl/core/skvt_rsp_if.sv
// Result channel interface of the sorted key/datum table.
// Depends on skvt_pkg.
`timescale 1ns / 1ps
interface skvt_rsp_if
    import skvt_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        cursor_valid;
    logic signed [KEY_BITS-1:0] cur_key;
    logic [PORT_DATUM_BITS-1:0] cur_datum;
    logic [4:0]  entry_count;

    modport source (output valid, status, cursor_valid, cur_key, cur_datum,
                    entry_count, input ready);
    modport sink   (input valid, status, cursor_valid, cur_key, cur_datum,
                    entry_count, output ready);
endinterface

>>> rtl/core/sorted_key_value_table.sv
// Sorted key/datum table with a cursor, kept in one synchronous memory.
// Depends on skvt_pkg, skvt_req_if and skvt_rsp_if.
//
//   channel | dir | payload
//   req     | in  | mode, key_in, datum_in
//   rsp     | out | status, cursor_valid, cur_key, cur_datum, entry_count
//
// One request is handled at a time. A search reads entries one a cycle from
// index zero until the first key not below the request key; an insert or
// remove then shifts the tail one entry at a time (read, then write), and a
// final read fetches the cursor entry. All reads and writes go through the
// single memory port; the longest operation is an insert at the front of a
// table holding ENTRIES-1 entries.
// Reset clears count and cursor; stored entries stay undefined until written.
// The result sits in an output register until taken; a new request is taken
// in the cycle after it is.
`timescale 1ns / 1ps
module sorted_key_value_table
    import skvt_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEFAULT,
    parameter int DATUM_BITS = DATUM_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    skvt_req_if.sink   req,
    skvt_rsp_if.source rsp
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int MW = KEY_BITS + DATUM_BITS;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SEARCH = 8'b0000_0010,
        S_DECIDE = 8'b0000_0100,
        S_SHRD   = 8'b0000_1000,
        S_SHWR   = 8'b0001_0000,
        S_PUT    = 8'b0010_0000,
        S_CURRD  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    // Table storage: key in the upper bits, datum below.
    logic [MW-1:0] mem [ENTRIES];
    logic [MW-1:0] rd_data_reg;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [MW-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic          live_reg, live_next;
    logic [CW-1:0] pos_reg, pos_next;     // search index
    logic [CW-1:0] sh_reg, sh_next;       // shift index
    logic [2:0]    mode_reg;
    logic signed [KEY_BITS-1:0] key_reg;
    logic [DATUM_BITS-1:0] datum_reg;
    logic [1:0]    status_reg, status_next;
    logic          ovalid_reg, ovalid_next;
    logic          hit_reg, hit_next;

    logic signed [KEY_BITS-1:0] rd_key;
    logic [DATUM_BITS-1:0]      rd_datum;
    assign rd_key   = rd_data_reg[MW-1 -: KEY_BITS];
    assign rd_datum = rd_data_reg[DATUM_BITS-1:0];

    logic take;
    assign req.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign take      = req.valid && req.ready;

    // Result register outputs.
    assign rsp.valid        = ovalid_reg;
    assign rsp.status       = status_reg;
    assign rsp.cursor_valid = live_reg;
    assign rsp.cur_key      = live_reg ? rd_key : '0;
    assign rsp.cur_datum    = live_reg ? PORT_DATUM_BITS'({{64{1'b0}}, rd_datum}) : '0;
    assign rsp.entry_count  = 5'(count_reg);

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        live_next   = live_reg;
        pos_next    = pos_reg;
        sh_next     = sh_reg;
        status_next = status_reg;
        ovalid_next = ovalid_reg;
        hit_next    = hit_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = {key_reg, datum_reg};
        if (rsp.valid && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    status_next = ST_OK;
                    pos_next    = '0;
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                // Check the entry read last cycle (pos_reg-1), then read pos_reg.
                if (pos_reg != '0 && rd_key >= key_reg)
                begin
                    pos_next   = pos_reg - 1'b1;
                    hit_next   = (rd_key == key_reg);
                    state_next = S_DECIDE;
                end
                else if (pos_reg == count_reg)
                begin
                    hit_next   = 1'b0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = pos_reg[IW-1:0];
                    pos_next = pos_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                state_next = S_CURRD;
                unique case (mode_reg)
                    OP_INSERT:
                    begin
                        live_next = 1'b0;
                        cur_next  = '0;
                        if (hit_reg)
                        begin
                            state_next = S_PUT;
                        end
                        else if (count_reg == CW'(ENTRIES))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            sh_next    = count_reg;
                            count_next = count_reg + 1'b1;
                            state_next = (count_reg == pos_reg) ? S_PUT : S_SHRD;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                            sh_next    = pos_reg;
                            if (live_reg && CW'(cur_reg) == pos_reg)
                            begin
                                live_next = 1'b0;
                                cur_next  = '0;
                            end
                            else if (live_reg && CW'(cur_reg) > pos_reg)
                            begin
                                cur_next = cur_reg - 1'b1;
                            end
                            state_next = (pos_reg + 1'b1 < count_reg) ? S_SHRD : S_CURRD;
                        end
                    end
                    OP_FIND:
                    begin
                        live_next = hit_reg;
                        cur_next  = hit_reg ? pos_reg[IW-1:0] : '0;
                        if (!hit_reg)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_FIRST:
                    begin
                        cur_next  = '0;
                        live_next = (count_reg != '0);
                    end
                    OP_NEXT:
                    begin
                        if (!live_reg)
                        begin
                            status_next = ST_CURSOR;
                        end
                        else if (CW'(cur_reg) + 1'b1 < count_reg)
                        begin
                            cur_next = cur_reg + 1'b1;
                        end
                        else
                        begin
                            live_next = 1'b0;
                            cur_next  = '0;
                        end
                    end
                    OP_CLEAR:
                    begin
                        count_next = '0;
                        live_next  = 1'b0;
                        cur_next   = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SHRD:
            begin
                // Insert moves entry sh-1 up; remove moves entry sh+1 down.
                rd_en      = 1'b1;
                rd_addr    = (mode_reg == OP_INSERT) ? IW'(sh_reg - 1'b1)
                                                     : IW'(sh_reg + 1'b1);
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                wr_en   = 1'b1;
                wr_addr = sh_reg[IW-1:0];
                wr_data = rd_data_reg;
                if (mode_reg == OP_INSERT)
                begin
                    sh_next    = sh_reg - 1'b1;
                    state_next = (sh_reg - 1'b1 == pos_reg) ? S_PUT : S_SHRD;
                end
                else
                begin
                    sh_next    = sh_reg + 1'b1;
                    state_next = (sh_reg + 1'b1 < count_reg) ? S_SHRD : S_CURRD;
                end
            end
            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[IW-1:0];
                state_next = S_CURRD;
            end
            S_CURRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = cur_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cur_reg    <= '0;
            live_reg   <= 1'b0;
            pos_reg    <= '0;
            sh_reg     <= '0;
            status_reg <= ST_OK;
            ovalid_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cur_reg    <= cur_next;
            live_reg   <= live_next;
            pos_reg    <= pos_next;
            sh_reg     <= sh_next;
            status_reg <= status_next;
            ovalid_reg <= ovalid_next;
            hit_reg    <= hit_next;
        end
    end

    // Request payload capture.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mode_reg  <= req.mode;
            key_reg   <= req.key_in;
            datum_reg <= DATUM_BITS'({{64{1'b0}}, req.datum_in});
        end
    end

endmodule

>>> sim/tb_sorted_key_value_table.sv
// Self-checking testbench for the sorted key/datum table with a cursor.
// Depends on skvt_pkg, skvt_req_if, skvt_rsp_if and sorted_key_value_table.
`timescale 1ns / 1ps
module tb_sorted_key_value_table;
    import skvt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int IDLE_LIMIT  = 20000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] key;
        logic [31:0] datum;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        cursor_valid;
        logic [31:0] cur_key;
        logic [31:0] cur_datum;
        logic [4:0]  entry_count;
    } table_result_t;

    logic clk;
    logic rst_n;

    skvt_req_if req_ch ();
    skvt_rsp_if rsp_ch ();

    sorted_key_value_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Shadow copy of the table contents.
    logic [31:0] shadow_keys [TABLE_DEPTH];
    logic [31:0] shadow_data [TABLE_DEPTH];
    int          shadow_count;
    int          shadow_cursor;
    bit          shadow_live;

    request_t      pending_requests [$];
    table_result_t expected_results [$];
    int            error_count;
    int            idle_cycles;
    bit            hold_sender;
    bit            hold_receiver;

    // Predicts the result of one request and updates the shadow table.
    function automatic table_result_t apply_request(request_t r);
        table_result_t res;
        int pos;
        bit hit;
        res = '0;
        pos = 0;
        while (pos < shadow_count && $signed(shadow_keys[pos]) < $signed(r.key))
            pos++;
        hit = pos < shadow_count && shadow_keys[pos] == r.key;
        res.status = ST_OK;
        case (r.mode)
            OP_INSERT:
            begin
                if (hit)
                    shadow_data[pos] = r.datum;
                else if (shadow_count >= TABLE_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = shadow_count; i > pos; i--)
                    begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_data[i] = shadow_data[i-1];
                    end
                    shadow_keys[pos] = r.key;
                    shadow_data[pos] = r.datum;
                    shadow_count++;
                end
                shadow_live = 0;
                shadow_cursor = 0;
            end
            OP_REMOVE:
            begin
                if (!hit)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    for (int i = pos; i + 1 < shadow_count; i++)
                    begin
                        shadow_keys[i] = shadow_keys[i+1];
                        shadow_data[i] = shadow_data[i+1];
                    end
                    shadow_count--;
                    if (shadow_live && shadow_cursor == pos)
                    begin
                        shadow_live = 0;
                        shadow_cursor = 0;
                    end
                    else if (shadow_live && shadow_cursor > pos)
                        shadow_cursor--;
                end
            end
            OP_FIND:
            begin
                shadow_live = hit;
                shadow_cursor = hit ? pos : 0;
                if (!hit)
                    res.status = ST_NOT_FOUND;
            end
            OP_FIRST:
            begin
                shadow_cursor = 0;
                shadow_live = shadow_count > 0;
            end
            OP_NEXT:
            begin
                if (!shadow_live)
                    res.status = ST_CURSOR;
                else if (shadow_cursor + 1 < shadow_count)
                    shadow_cursor++;
                else
                begin
                    shadow_live = 0;
                    shadow_cursor = 0;
                end
            end
            OP_CLEAR:
            begin
                shadow_count = 0;
                shadow_live = 0;
                shadow_cursor = 0;
            end
            default:
            begin
            end
        endcase
        if (shadow_live && shadow_cursor >= shadow_count)
        begin
            shadow_live = 0;
            shadow_cursor = 0;
        end
        res.cursor_valid = shadow_live;
        res.cur_key      = shadow_live ? shadow_keys[shadow_cursor] : '0;
        res.cur_datum    = shadow_live ? shadow_data[shadow_cursor] : '0;
        res.entry_count  = shadow_count[4:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
    endtask

    // Picks a key that is often already stored, so hits are common.
    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && shadow_count > 0)
            return shadow_keys[$urandom_range(0, shadow_count - 1)];
        if (sel < 8)
            return 32'($signed($urandom_range(0, 40)) - 20);
        if (sel == 8)
            return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        return $urandom;
    endfunction

    task automatic queue_request(logic [2:0] mode, logic [31:0] key, logic [31:0] datum);
        request_t r;
        r.mode = mode;
        r.key = key;
        r.datum = datum;
        pending_requests.push_back(r);
    endtask

    // Waits until the driver has sent everything queued so far.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || req_ch.valid)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Driver: sends requests in bursts with random gaps.
    initial
    begin : driver_gaps
        req_ch.valid = 0;
        req_ch.mode = '0;
        req_ch.key_in = '0;
        req_ch.datum_in = '0;
    end

    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (req_ch.valid && req_ch.ready)
                expected_results.push_back(apply_request(
                    request_t'{req_ch.mode, req_ch.key_in, req_ch.datum_in}));
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                req_ch.valid <= 0;
            end
            else if (!hold_sender && pending_requests.size() != 0)
            begin
                request_t r;
                r = pending_requests.pop_front();
                req_ch.valid <= 1;
                req_ch.mode <= r.mode;
                req_ch.key_in <= r.key;
                req_ch.datum_in <= r.datum;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req_ch.valid <= 0;
        end
    end

    // Receiver: stalls on its own pattern, plus a long hold when asked.
    int stall_phase;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (hold_receiver)
                rsp_ch.ready <= 0;
            else if (stall_phase[9:8] == 2'd0)
                rsp_ch.ready <= 1;
            else
                rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: compares each result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", 32'd1, 32'd0);
            end
            else
            begin
                table_result_t want;
                want = expected_results.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", rsp_ch.status, want.status);
                if (rsp_ch.cursor_valid !== want.cursor_valid)
                    report_mismatch("cursor_valid", rsp_ch.cursor_valid, want.cursor_valid);
                if (rsp_ch.cur_key !== want.cur_key)
                    report_mismatch("cur_key", rsp_ch.cur_key, want.cur_key);
                if (rsp_ch.cur_datum !== want.cur_datum)
                    report_mismatch("cur_datum", rsp_ch.cur_datum, want.cur_datum);
                if (rsp_ch.entry_count !== want.entry_count)
                    report_mismatch("entry_count", rsp_ch.entry_count, want.entry_count);
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no handshake.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int mode_pick;
        rst_n = 0;
        error_count = 0;
        idle_cycles = 0;
        hold_sender = 0;
        hold_receiver = 0;
        shadow_count = 0;
        shadow_cursor = 0;
        shadow_live = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;

        // Directed part: empty-table cases, extremes, ordering, full table.
        queue_request(OP_NEXT, 0, 0);
        queue_request(OP_FIRST, 0, 0);
        queue_request(OP_REMOVE, 5, 0);
        queue_request(OP_FIND, 5, 0);
        queue_request(OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
        queue_request(OP_INSERT, 32'h8000_0000, 32'h0000_0000);
        queue_request(OP_INSERT, 32'h0, 32'h5555_aaaa);
        queue_request(OP_INSERT, 32'h0, 32'haaaa_5555);
        queue_request(OP_FIRST, 0, 0);
        queue_request(OP_NEXT, 0, 0);
        queue_request(OP_NEXT, 0, 0);
        queue_request(OP_NEXT, 0, 0);
        queue_request(OP_FIND, 32'h7fff_ffff, 0);
        queue_request(OP_REMOVE, 32'h8000_0000, 0);
        queue_request(OP_REMOVE, 32'h7fff_ffff, 0);
        queue_request(3'd6, 0, 0);
        queue_request(3'd7, 32'hffff_ffff, 32'hffff_ffff);
        for (int i = 0; i < 17; i++)
            queue_request(OP_INSERT, 32'(i * 3 - 20), $urandom);
        queue_request(OP_CLEAR, 0, 0);
        wait_drained();

        // Long receiver hold while the sender keeps offering requests.
        hold_receiver = 1;
        for (int i = 0; i < 20; i++)
            queue_request(OP_INSERT, pick_key(), $urandom);
        repeat (300) @(posedge clk);
        hold_receiver = 0;
        wait_drained();

        // Random part: mostly table traffic around a small key range.
        for (int n = 0; n < 1200; n++)
        begin
            mode_pick = $urandom_range(0, 99);
            if (mode_pick < 35)
                queue_request(OP_INSERT, pick_key(), $urandom);
            else if (mode_pick < 55)
                queue_request(OP_REMOVE, pick_key(), $urandom);
            else if (mode_pick < 68)
                queue_request(OP_FIND, pick_key(), $urandom);
            else if (mode_pick < 75)
                queue_request(OP_FIRST, $urandom, $urandom);
            else if (mode_pick < 95)
                queue_request(OP_NEXT, $urandom, $urandom);
            else if (mode_pick < 97)
                queue_request(OP_CLEAR, $urandom, $urandom);
            else
                queue_request(3'($urandom_range(6, 7)), $urandom, $urandom);
            if (n % 60 == 59)
            begin
                wait_drained();
                // Sender pause until every result is back.
                hold_sender = 1;
                while (expected_results.size() != 0)
                    @(posedge clk);
                hold_sender = 0;
            end
        end
        wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
